[rtl/core/qdd_pkg.sv]
// Shared types, codes and helper functions for the quadrature detent decoder.
// No dependencies; every other file in rtl/core uses it.
package qdd_pkg;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned GAP_W      = 24;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 24;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENCODER_TYPE       = 8'd0,
		REG_JUMP_CHECK_ENABLE  = 8'd1,
		REG_MIN_STATE_GAP_US   = 8'd2,
		REG_MIN_REVERSE_GAP_US = 8'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ENC_ALL_DETENT = 2'd0,
		ENC_DETENT_1_2 = 2'd1,
		ENC_DETENT_0_3 = 2'd2,
		ENC_DETENT_0   = 2'd3
	} enc_type_t;

	typedef enum logic [1:0] {
		DIR_UNKNOWN = 2'd0,
		DIR_UP      = 2'd1,
		DIR_DOWN    = 2'd2
	} dir_t;

	typedef struct packed {
		enc_type_t          encoder_type;
		logic               jump_check_enable;
		logic [GAP_W-1:0]   min_state_gap_us;
		logic [GAP_W-1:0]   min_reverse_gap_us;
	} cfg_t;

	typedef struct packed {
		logic               line_a;
		logic               line_b;
		logic [TIME_W-1:0]  now_us;
	} sample_t;

	typedef struct packed {
		logic [1:0]         current_quad;
		logic [TIME_W-1:0]  last_sample_time;
		dir_t               held_direction;
		logic [TIME_W-1:0]  last_direction_time;
	} state_t;

	typedef struct packed {
		logic step;
		logic direction_up;
	} result_t;

	function automatic logic is_detent(enc_type_t t, logic [1:0] q);
		logic r;
		unique case (t)
			ENC_ALL_DETENT: r = 1'b1;
			ENC_DETENT_1_2: r = (q == 2'd1) || (q == 2'd2);
			ENC_DETENT_0_3: r = (q == 2'd0) || (q == 2'd3);
			ENC_DETENT_0:   r = (q == 2'd0);
			default:        r = 1'b0;
		endcase
		return r;
	endfunction

	// state that precedes q on the up sequence 0->2->3->1->0
	function automatic logic [1:0] up_pred(logic [1:0] q);
		logic [1:0] r;
		unique case (q)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd3;
			2'd2:    r = 2'd0;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	// true when 0 < d < gap, d taken over the full timestamp width
	function automatic logic too_soon(logic [TIME_W-1:0] d, logic [GAP_W-1:0] gap);
		return (d != '0) && (d[TIME_W-1:GAP_W] == '0) && (d[GAP_W-1:0] < gap);
	endfunction

endpackage

[rtl/core/qdd_ifs.sv]
// Handshake channels of the quadrature detent decoder: samples, results, config writes.
// Depends on qdd_pkg for widths.
interface qdd_sample_if;
	logic                             valid;
	logic                             ready;
	logic                             line_a;
	logic                             line_b;
	logic [qdd_pkg::TIME_W-1:0]       now_us;

	modport source(output valid, line_a, line_b, now_us, input ready);
	modport sink(input valid, line_a, line_b, now_us, output ready);
endinterface

interface qdd_result_if;
	logic valid;
	logic ready;
	logic step;
	logic direction_up;

	modport source(output valid, step, direction_up, input ready);
	modport sink(input valid, step, direction_up, output ready);
endinterface

interface qdd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [qdd_pkg::CFG_IDX_W-1:0]    index;
	logic [qdd_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/core/qdd_step_eval.sv]
// Per-sample decision: filters, detent test and direction hold, as next-state logic.
// Depends on qdd_pkg.
module qdd_step_eval (
	input  qdd_pkg::cfg_t    cfg,
	input  qdd_pkg::state_t  state,
	input  qdd_pkg::sample_t sample,
	output qdd_pkg::state_t  state_next,
	output qdd_pkg::result_t res
);

	logic [1:0]                  nq;
	logic [1:0]                  old_q;
	logic                        jump;
	logic                        take;
	logic                        report;
	logic [qdd_pkg::TIME_W-1:0]  d_sample;
	logic [qdd_pkg::TIME_W-1:0]  d_dir;
	qdd_pkg::dir_t               dir_new;
	qdd_pkg::dir_t               dir_out;

	always_comb begin
		nq       = {sample.line_b, sample.line_a};
		old_q    = state.current_quad;
		jump     = cfg.jump_check_enable && (cfg.encoder_type == qdd_pkg::ENC_DETENT_0_3)
			&& ((old_q ^ nq) == 2'b11);
		d_sample = sample.now_us - state.last_sample_time;
		take     = !jump && !qdd_pkg::too_soon(d_sample, cfg.min_state_gap_us);
		report   = take && (old_q != nq) && qdd_pkg::is_detent(cfg.encoder_type, nq);
		dir_new  = (qdd_pkg::up_pred(nq) == old_q) ? qdd_pkg::DIR_UP : qdd_pkg::DIR_DOWN;
		d_dir    = sample.now_us - state.last_direction_time;

		state_next = state;
		dir_out    = dir_new;
		if (take) begin
			state_next.current_quad     = nq;
			state_next.last_sample_time = sample.now_us;
		end
		if (report) begin
			// a reversal too close to the last step keeps the held direction
			if (dir_new != state.held_direction) begin
				if (qdd_pkg::too_soon(d_dir, cfg.min_reverse_gap_us)) begin
					dir_out = state.held_direction;
				end else begin
					state_next.held_direction = dir_new;
				end
			end
			state_next.last_direction_time = sample.now_us;
		end

		res.step         = report;
		res.direction_up = report && (dir_out == qdd_pkg::DIR_UP);
	end

endmodule

[rtl/core/quadrature_detent_decoder.sv]
// Quadrature detent decoder top level: input register, decision logic, result register.
// A result enters the result register when its sample leaves the input register.
// Throughput: one sample per cycle unless stalled; input register frees as result moves.
// Reset (arst_n low, async): config registers, decoder state and valid flags clear to zero.
// Depends on qdd_pkg, qdd_ifs and qdd_step_eval.
module quadrature_detent_decoder (
	input  logic      clk,
	input  logic      arst_n,
	qdd_sample_if.sink   sample,
	qdd_result_if.source result,
	qdd_cfg_if.sink      cfg
);

	qdd_pkg::cfg_t     cfg_q;
	qdd_pkg::state_t   state_q;
	qdd_pkg::state_t   state_next;
	qdd_pkg::sample_t  sample_s1;
	logic              valid_s1;
	qdd_pkg::result_t  res_next;
	qdd_pkg::result_t  res_q;
	logic              out_valid_q;
	logic              advance;
	qdd_pkg::reg_idx_t cfg_idx;

	assign cfg.ready = 1'b1;
	assign cfg_idx   = qdd_pkg::reg_idx_t'(cfg.index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_idx)
				qdd_pkg::REG_ENCODER_TYPE: begin
					cfg_q.encoder_type <= qdd_pkg::enc_type_t'(cfg.data[1:0]);
				end
				qdd_pkg::REG_JUMP_CHECK_ENABLE: begin
					cfg_q.jump_check_enable <= cfg.data[0];
				end
				qdd_pkg::REG_MIN_STATE_GAP_US: begin
					cfg_q.min_state_gap_us <= cfg.data[qdd_pkg::GAP_W-1:0];
				end
				qdd_pkg::REG_MIN_REVERSE_GAP_US: begin
					cfg_q.min_reverse_gap_us <= cfg.data[qdd_pkg::GAP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1.line_a <= sample.line_a;
			sample_s1.line_b <= sample.line_b;
			sample_s1.now_us <= sample.now_us;
		end
	end

	qdd_step_eval u_eval (
		.cfg        (cfg_q),
		.state      (state_q),
		.sample     (sample_s1),
		.state_next (state_next),
		.res        (res_next)
	);

	// state moves together with the sample leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.step         = res_q.step;
	assign result.direction_up = res_q.direction_up;

endmodule
